// File: hw/rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg: shared types and constants for the rotated rectangle corner unit
// fixed-point formats, cordic angle table and the word carried along the chain
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int FRACTION_BITS = 16;
    localparam int STEP_W        = 5;

    // reciprocal of the limit cordic gain in Q2.30
    localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

    localparam logic [7:0] REG_WORLD_HEIGHT = 8'd0;
    localparam logic [7:0] REG_PIXEL_SCALE  = 8'd1;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic [1:0]         quad;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        w;
        logic [30:0]        h;
    } t_cord;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rrc_cordic_cell.sv
// ----------------------------------------------------------------------------
// rrc_cordic_cell: one rotation-mode cordic iteration
// registers the rotated vector, residual angle and the rectangle word
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_cordic_cell import rrc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire logic              i_valid,
    input  wire t_cord             i_word,
    output logic                   o_valid,
    output t_cord                  o_word
);

    logic  r_valid;
    t_cord r_word;
    t_cord n_word;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] da;

    always_comb begin
        dx = i_word.y >>> i_step;
        dy = i_word.x >>> i_step;
        da = $signed({1'b0, atan_turns(i_step)});
        n_word = i_word;
        if (!i_word.z[32]) begin
            n_word.x = i_word.x - dx;
            n_word.y = i_word.y + dy;
            n_word.z = i_word.z - da;
        end else begin
            n_word.x = i_word.x + dx;
            n_word.y = i_word.y - dy;
            n_word.z = i_word.z + da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// File: hw/rtl/rrc_corner_unit.sv
// ----------------------------------------------------------------------------
// rrc_corner_unit: corner sequencer and pixel mapping pipeline
// holds one rectangle's products, emits four corners one per unstalled cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_corner_unit import rrc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_cord       i_word,
    output logic             o_take,
    input  wire logic [30:0] i_world_height,
    input  wire logic [30:0] i_pixel_scale,
    output logic             o_valid,
    output logic [1:0]       o_corner,
    output logic [31:0]      o_pixel_x,
    output logic [31:0]      o_pixel_y,
    input  wire logic        i_ready
);

    // product stage, also the corner sequencer
    logic               r_p_v;
    logic [1:0]         r_k;
    logic signed [63:0] r_a, r_b, r_c, r_d;
    logic signed [31:0] r_p_cx, r_p_cy;
    logic signed [32:0] cs, sn;
    logic               en_t;

    // rotate stage
    logic               r_e1_v;
    logic [1:0]         r_e1_k;
    logic signed [34:0] r_rx, r_ry;
    logic signed [31:0] r_e1_cx, r_e1_cy;
    logic signed [65:0] sum_x, sum_y, ta, tb, tc, td;

    // translate stage
    logic               r_e2_v;
    logic [1:0]         r_e2_k;
    logic               r_nx, r_ny;
    logic [35:0]        r_mx, r_my;
    logic signed [35:0] px, py;

    // multiply stage
    logic               r_e3_v;
    logic [1:0]         r_e3_k;
    logic               r_e3_nx, r_e3_ny;
    logic [62:0]        r_lx, r_ly;
    logic [34:0]        r_hx, r_hy;

    // output word
    logic               r_o_v;
    logic [1:0]         r_o_k;
    logic [31:0]        r_ox, r_oy;
    logic [31:0]        n_ox, n_oy;

    function automatic logic [31:0] round_sat(input logic [62:0] lo, input logic [34:0] hi,
                                              input logic neg);
        logic [67:0] p;
        logic [67:0] q;
        logic [31:0] r;
        p = 68'(lo) + (68'(hi) << 32) + (68'd1 << (FRACTION_BITS - 1));
        q = p >> FRACTION_BITS;
        if (neg) begin
            if (q > 68'h80000000) begin
                r = 32'h80000000;
            end else begin
                r = 32'd0 - q[31:0];
            end
        end else begin
            if (q > 68'h7FFFFFFF) begin
                r = 32'h7FFFFFFF;
            end else begin
                r = q[31:0];
            end
        end
        return r;
    endfunction

    assign en_t   = !r_o_v || i_ready;
    assign o_take = !r_p_v || (en_t && (r_k == 2'd3));

    always_comb begin
        unique case (i_word.quad)
            2'd1: begin cs = -i_word.y; sn = i_word.x;  end
            2'd2: begin cs = -i_word.x; sn = -i_word.y; end
            2'd3: begin cs = i_word.y;  sn = -i_word.x; end
            default: begin cs = i_word.x; sn = i_word.y; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_k   <= 2'd0;
        end else begin
            if (o_take) begin
                r_p_v <= i_valid;
                r_k   <= 2'd0;
            end else if (en_t) begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_a    <= $signed({1'b0, i_word.w}) * cs;
            r_b    <= $signed({1'b0, i_word.h}) * sn;
            r_c    <= $signed({1'b0, i_word.w}) * sn;
            r_d    <= $signed({1'b0, i_word.h}) * cs;
            r_p_cx <= i_word.cx;
            r_p_cy <= i_word.cy;
        end
    end

    // corner signs: x negative on corners 0 and 3, y negative on 0 and 1
    always_comb begin
        ta = 66'(r_a);
        tb = 66'(r_b);
        tc = 66'(r_c);
        td = 66'(r_d);
        if (r_k == 2'd0 || r_k == 2'd3) begin
            ta = -ta;
            tc = -tc;
        end
        if (r_k == 2'd2 || r_k == 2'd3) begin
            tb = -tb;
        end else begin
            td = -td;
        end
        sum_x = ta + tb + (66'sd1 <<< 30);
        sum_y = tc + td + (66'sd1 <<< 30);
    end

    always_comb begin
        px = 36'(r_e1_cx) + 36'(r_rx);
        py = $signed({5'd0, i_world_height}) - 36'(r_e1_cy) - 36'(r_ry);
    end

    assign n_ox = round_sat(r_lx, r_hx, r_e3_nx);
    assign n_oy = round_sat(r_ly, r_hy, r_e3_ny);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (en_t) begin
            r_e1_v <= r_p_v;
            r_e2_v <= r_e1_v;
            r_e3_v <= r_e2_v;
            r_o_v  <= r_e3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_t) begin
            r_e1_k  <= r_k;
            r_rx    <= sum_x[65:31];
            r_ry    <= sum_y[65:31];
            r_e1_cx <= r_p_cx;
            r_e1_cy <= r_p_cy;

            r_e2_k  <= r_e1_k;
            r_nx    <= px[35];
            r_ny    <= py[35];
            r_mx    <= px[35] ? 36'(-px) : 36'(px);
            r_my    <= py[35] ? 36'(-py) : 36'(py);

            r_e3_k  <= r_e2_k;
            r_e3_nx <= r_nx;
            r_e3_ny <= r_ny;
            r_lx    <= r_mx[31:0] * i_pixel_scale;
            r_ly    <= r_my[31:0] * i_pixel_scale;
            r_hx    <= r_mx[35:32] * i_pixel_scale;
            r_hy    <= r_my[35:32] * i_pixel_scale;

            r_o_k   <= r_e3_k;
            r_ox    <= n_ox;
            r_oy    <= n_oy;
        end
    end

    assign o_valid   = r_o_v;
    assign o_corner  = r_o_k;
    assign o_pixel_x = r_ox;
    assign o_pixel_y = r_oy;

endmodule

`default_nettype wire

// File: hw/rtl/rotated_rectangle_corners_unit.sv
// ----------------------------------------------------------------------------
// rotated_rectangle_corners_unit: corners of a rotated rectangle in pixels
//
// The input stream takes one rectangle per word: center, angle, width and
// height. The output stream gives four words per rectangle, corners 0 to 3,
// with tlast on corner 3. Sine and cosine come from a chain of sixteen cordic
// cells that step forward together; a corner sequencer at the end of the chain
// holds one rectangle and issues one corner per cycle unless the output stalls,
// into a four-stage rotate, translate, multiply and round pipeline ending in
// the output register. The sequencer takes a new rectangle only as it issues
// corner 3 of the current one. A stalled receiver freezes the corner pipeline,
// then the sequencer, then the cordic chain, and tready drops; nothing is
// lost. Reset clears all valid bits and loads world_height = 1.0 and
// pixel_scale = 800.0. The configuration channel is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_rectangle_corners_unit import rrc_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // center_x[31:0] center_y[63:32] angle[79:64] width[110:80] height[141:111]
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pixel_x[31:0] pixel_y[63:32]
    output logic [63:0]       m_tdata,
    // corner[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [30:0]  i_cfg_data
);

    logic [30:0] r_world_height;
    logic [30:0] r_pixel_scale;
    t_cord       head;
    t_cord       words [CORDIC_STEPS];
    logic        valids [CORDIC_STEPS];
    logic        take;
    logic        en_c;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_height <= 31'd65536;
            r_pixel_scale  <= 31'd52428800;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WORLD_HEIGHT) begin
                r_world_height <= i_cfg_data;
            end
            if (i_cfg_index == REG_PIXEL_SCALE) begin
                r_pixel_scale <= i_cfg_data;
            end
        end
    end

    always_comb begin
        head.x    = GAIN_Q30;
        head.y    = '0;
        head.z    = $signed({3'b000, s_tdata[77:64], 16'd0});
        head.quad = s_tdata[79:78];
        head.cx   = s_tdata[31:0];
        head.cy   = s_tdata[63:32];
        head.w    = s_tdata[110:80];
        head.h    = s_tdata[141:111];
    end

    // chain advances unless its last word waits on the sequencer
    assign en_c     = !valids[CORDIC_STEPS-1] || take;
    assign s_tready = en_c;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        rrc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en_c),
            .i_step  (STEP_W'(g)),
            .i_valid ((g == 0) ? s_tvalid : valids[(g == 0) ? 0 : g - 1]),
            .i_word  ((g == 0) ? head : words[(g == 0) ? 0 : g - 1]),
            .o_valid (valids[g]),
            .o_word  (words[g])
        );
    end

    rrc_corner_unit u_corner (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (valids[CORDIC_STEPS-1]),
        .i_word         (words[CORDIC_STEPS-1]),
        .o_take         (take),
        .i_world_height (r_world_height),
        .i_pixel_scale  (r_pixel_scale),
        .o_valid        (m_tvalid),
        .o_corner       (m_tuser),
        .o_pixel_x      (m_tdata[31:0]),
        .o_pixel_y      (m_tdata[63:32]),
        .i_ready        (m_tready)
    );

    assign m_tlast = (m_tuser == 2'd3);

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 2'd3)))
        else $error("tlast not on corner three");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_corner_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready && m_tuser != 2'd3 ##1 m_tvalid)
        |-> (m_tuser == $past(m_tuser) + 2'd1))
        else $error("corners out of order");

endmodule

`default_nettype wire
